/* design/combined_lcg_shuffle_rng_macros.svh */
// Assertion helpers for the file that checks its own logic.
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CLSR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CLSR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/clsr_pkg.sv */
`timescale 1ns / 1ps

package clsr_pkg;

  // Shuffle table geometry.
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int WARM_STEPS = TABLE_SIZE + 8;
  localparam int CNT_W = $clog2(WARM_STEPS);

  // Generator constants.
  localparam logic [30:0] MOD_A = 31'd2147483563;
  localparam logic [30:0] MOD_B = 31'd2147483399;
  localparam logic [15:0] MUL_A = 16'd40014;
  localparam logic [15:0] MUL_B = 16'd40692;
  localparam logic [15:0] QUO_A = 16'd53668;
  localparam logic [15:0] QUO_B = 16'd52774;
  localparam logic [13:0] REM_A = 14'd12211;
  localparam logic [13:0] REM_B = 14'd3791;
  localparam logic [30:0] SEED_B = 31'd123456789;
  localparam logic [30:0] TOP_VAL = MOD_A - 31'd1;

  // Schrage quotient x / QUO through a rounded-up reciprocal. With a shift of
  // 31 plus the quotient width the result is exact for any 31-bit x.
  localparam int K_W = 16;
  localparam int SCH_SHIFT = 31 + K_W;
  localparam longint QUO_A_L = longint'(QUO_A);
  localparam longint QUO_B_L = longint'(QUO_B);
  localparam logic [31:0] RECIP_A =
    32'(((longint'(1) << SCH_SHIFT) + QUO_A_L - 1) / QUO_A_L);
  localparam logic [31:0] RECIP_B =
    32'(((longint'(1) << SCH_SHIFT) + QUO_B_L - 1) / QUO_B_L);

  // Slot selection: previous output divided by the slot divisor, done the
  // same way with an exact rounded-up reciprocal.
  localparam longint SLOT_DIV = 1 + longint'(TOP_VAL) / TABLE_SIZE;
  localparam int SLOT_SHIFT = 31 + $clog2(SLOT_DIV);
  localparam logic [31:0] RECIP_SLOT =
    32'(((longint'(1) << SLOT_SHIFT) + SLOT_DIV - 1) / SLOT_DIV);

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_STEP_A = 2'd0,
    OP_STEP_B = 2'd1,
    OP_SLOT   = 2'd2
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [30:0] operand;
  } unit_req_t;

  typedef struct packed {
    logic        idle;
    logic        done;
    logic [30:0] result;
  } unit_rsp_t;

endpackage

/* design/combined_lcg_shuffle_rng.sv */
// Channel   Direction  Beat content
// s_*       in         tdata[0] reseed, bits 7:1 zero
// m_*       out        tdata[30:0] value, bit 31 zero
// cfg_*     in         seed register write, no read-back
//
// A draw runs two Schrage steps and a slot division on the shared multiplier unit,
// then a table read-modify-write state and an output load state. The next beat
// is taken only once the sequencer is back in idle, so the input takes no new
// request while a draw is in flight, and a result not yet taken holds it there.
// A beat with reseed set adds 40 warm-up steps.
// Reset sets the generators to their start values and clears the previous output and the table valid bits.
`timescale 1ns / 1ps
`include "combined_lcg_shuffle_rng_macros.svh"

module combined_lcg_shuffle_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,   // seed
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [0] reseed, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // [30:0] value, [31] zero
);
  import clsr_pkg::*;

  typedef enum logic [10:0] {
    T_IDLE  = 11'b00000000001,
    T_WARM  = 11'b00000000010,
    T_WWAIT = 11'b00000000100,
    T_STEPA = 11'b00000001000,
    T_WAITA = 11'b00000010000,
    T_STEPB = 11'b00000100000,
    T_WAITB = 11'b00001000000,
    T_SLOT  = 11'b00010000000,
    T_WAITS = 11'b00100000000,
    T_READ  = 11'b01000000000,
    T_EMIT  = 11'b10000000000
  } tstate_t;

  tstate_t state;
  logic [30:0] seed;
  logic [30:0] x;
  logic [30:0] y;
  logic [30:0] last_output;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] slot;
  logic [TABLE_SIZE-1:0] valid;
  logic [30:0] draw;
  logic [30:0] out_val;

  unit_req_t ureq;
  unit_rsp_t ursp;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [30:0] ram_wdata;
  logic ram_re;
  logic [30:0] ram_rdata;
  logic [30:0] tval;
  logic [30:0] draw_next;
  logic [30:0] seed_eff;
  logic warm_fill;

  // Seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 31'd1;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  assign seed_eff = (seed == '0) ? 31'd1 : seed;
  assign s_tready = (state == T_IDLE);

  // Requests to the shared arithmetic unit.
  always_comb begin
    ureq.start = 1'b0;
    ureq.op = OP_STEP_A;
    ureq.operand = x;
    case (state)
      T_WARM, T_STEPA: begin
        ureq.start = 1'b1;
      end
      T_STEPB: begin
        ureq.start = 1'b1;
        ureq.op = OP_STEP_B;
        ureq.operand = y;
      end
      T_SLOT: begin
        ureq.start = 1'b1;
        ureq.op = OP_SLOT;
        ureq.operand = last_output;
      end
      default: begin
        ureq.start = 1'b0;
      end
    endcase
  end

  clsr_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  // Table port: warm-up fill or the refill of the drawn slot.
  assign warm_fill = (state == T_WWAIT) && ursp.done && (cnt < CNT_W'(TABLE_SIZE));
  assign ram_we = warm_fill || (state == T_READ);
  assign ram_waddr = (state == T_READ) ? slot : cnt[IDX_W-1:0];
  assign ram_wdata = (state == T_READ) ? x : ursp.result;
  assign ram_re = (state == T_WAITS) && ursp.done;

  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ursp.result[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Shuffled output: table entry minus the second generator, wrapped.
  always_comb begin
    tval = valid[slot] ? ram_rdata : '0;
    if (tval > y) begin
      draw_next = tval - y;
    end else begin
      draw_next = 31'({1'b0, tval} + {1'b0, TOP_VAL} - {1'b0, y});
    end
  end

  // Draw sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      x <= 31'd1;
      y <= SEED_B;
      last_output <= '0;
      valid <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata[0]) begin
              x <= seed_eff;
              y <= seed_eff;
              cnt <= CNT_W'(WARM_STEPS - 1);
              state <= T_WARM;
            end else begin
              state <= T_STEPA;
            end
          end
        end
        T_WARM: begin
          state <= T_WWAIT;
        end
        T_WWAIT: begin
          if (ursp.done) begin
            x <= ursp.result;
            if (warm_fill) begin
              valid[cnt[IDX_W-1:0]] <= 1'b1;
            end
            if (cnt == '0) begin
              // Slot 0 was written last; it seeds the previous output.
              last_output <= ursp.result;
              state <= T_STEPA;
            end else begin
              cnt <= cnt - CNT_W'(1);
              state <= T_WARM;
            end
          end
        end
        T_STEPA: begin
          state <= T_WAITA;
        end
        T_WAITA: begin
          if (ursp.done) begin
            x <= ursp.result;
            state <= T_STEPB;
          end
        end
        T_STEPB: begin
          state <= T_WAITB;
        end
        T_WAITB: begin
          if (ursp.done) begin
            y <= ursp.result;
            state <= T_SLOT;
          end
        end
        T_SLOT: begin
          state <= T_WAITS;
        end
        T_WAITS: begin
          if (ursp.done) begin
            slot <= ursp.result[IDX_W-1:0];
            state <= T_READ;
          end
        end
        T_READ: begin
          valid[slot] <= 1'b1;
          last_output <= draw_next;
          draw <= draw_next;
          state <= T_EMIT;
        end
        T_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == T_EMIT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      out_val <= draw;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {1'b0, out_val};

  // Checks on the draw sequencer and the shared unit.
  `CLSR_ASSERT_NOW(a_out_range, clk, rst, m_tvalid, (out_val != '0) && (out_val <= TOP_VAL), "result beat outside the output range")
  `CLSR_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input ready right after an accepted beat")
  `CLSR_ASSERT_NOW(a_unit_start_idle, clk, rst, ureq.start, ursp.idle, "shared unit started while busy")

endmodule

/* design/clsr_ram.sv */
`timescale 1ns / 1ps

module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/clsr_unit.sv */
`timescale 1ns / 1ps

module clsr_unit (
  input  logic                clk,
  input  logic                rst,
  input  clsr_pkg::unit_req_t req,
  output clsr_pkg::unit_rsp_t rsp
);
  import clsr_pkg::*;

  typedef enum logic [6:0] {
    U_IDLE  = 7'b0000001,
    U_RECIP = 7'b0000010,
    U_KQ    = 7'b0000100,
    U_REM   = 7'b0001000,
    U_MR    = 7'b0010000,
    U_KR    = 7'b0100000,
    U_FIN   = 7'b1000000
  } ustate_t;

  ustate_t state;
  op_t opr;
  logic [30:0] v;
  logic [K_W-1:0] k;
  logic [K_W-1:0] rem;
  logic [30:0] acc;
  logic [63:0] prod;
  logic done;
  logic [30:0] result;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] c_recip;
  logic [31:0] c_quo;
  logic [31:0] c_mul;
  logic [31:0] c_remc;
  logic [30:0] c_mod;
  logic [30:0] diff;
  logic [30:0] fin_res;
  logic [63:0] slot_q;
  logic [IDX_W-1:0] slot_idx;

  // Constants of the generator being stepped, or the slot reciprocal for a slot division.
  always_comb begin
    case (opr)
      OP_STEP_A: begin
        c_recip = RECIP_A;
        c_quo = 32'(QUO_A);
        c_mul = 32'(MUL_A);
        c_remc = 32'(REM_A);
        c_mod = MOD_A;
      end
      OP_STEP_B: begin
        c_recip = RECIP_B;
        c_quo = 32'(QUO_B);
        c_mul = 32'(MUL_B);
        c_remc = 32'(REM_B);
        c_mod = MOD_B;
      end
      default: begin
        c_recip = RECIP_SLOT;
        c_quo = 32'(QUO_A);
        c_mul = 32'(MUL_A);
        c_remc = 32'(REM_A);
        c_mod = MOD_A;
      end
    endcase
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    case (state)
      U_KQ: begin
        mul_a = {{(32 - K_W){1'b0}}, prod[SCH_SHIFT +: K_W]};
        mul_b = c_quo;
      end
      U_MR: begin
        mul_a = {{(32 - K_W){1'b0}}, rem};
        mul_b = c_mul;
      end
      U_KR: begin
        mul_a = {{(32 - K_W){1'b0}}, k};
        mul_b = c_remc;
      end
      default: begin
        mul_a = {1'b0, v};
        mul_b = c_recip;
      end
    endcase
  end

  // Remainder, final Schrage combine and slot quotient with clamp.
  always_comb begin
    diff = v - prod[30:0];
    if (acc >= prod[30:0]) begin
      fin_res = acc - prod[30:0];
    end else begin
      fin_res = 31'({1'b0, acc} + {1'b0, c_mod} - {1'b0, prod[30:0]});
    end
    slot_q = prod >> SLOT_SHIFT;
    if (slot_q >= 64'(TABLE_SIZE)) begin
      slot_idx = IDX_W'(TABLE_SIZE - 1);
    end else begin
      slot_idx = slot_q[IDX_W-1:0];
    end
  end

  // Product register, updated every cycle.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            opr <= req.op;
            v <= req.operand;
            state <= U_RECIP;
          end
        end
        U_RECIP: begin
          state <= U_KQ;
        end
        U_KQ: begin
          if (opr == OP_SLOT) begin
            result <= {{(31 - IDX_W){1'b0}}, slot_idx};
            done <= 1'b1;
            state <= U_IDLE;
          end else begin
            k <= prod[SCH_SHIFT +: K_W];
            state <= U_REM;
          end
        end
        U_REM: begin
          rem <= diff[K_W-1:0];
          state <= U_MR;
        end
        U_MR: begin
          state <= U_KR;
        end
        U_KR: begin
          acc <= prod[30:0];
          state <= U_FIN;
        end
        U_FIN: begin
          result <= fin_res;
          done <= 1'b1;
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp.idle = (state == U_IDLE);
  assign rsp.done = done;
  assign rsp.result = result;

endmodule

/* dv/tb_combined_lcg_shuffle_rng.sv */
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_rng;

  // Generator constants, kept independent of the design package.
  localparam int SLOTS = 32;
  localparam int WARMUP = SLOTS + 8;
  localparam longint MODULUS_1 = 64'd2147483563;
  localparam longint MODULUS_2 = 64'd2147483399;
  localparam longint MULT_1 = 64'd40014;
  localparam longint MULT_2 = 64'd40692;
  localparam longint QUOT_1 = 64'd53668;
  localparam longint QUOT_2 = 64'd52774;
  localparam longint REMD_1 = 64'd12211;
  localparam longint REMD_2 = 64'd3791;
  localparam longint RANGE_TOP = MODULUS_1 - 1;
  localparam longint SLOT_WIDTH = 1 + RANGE_TOP / SLOTS;
  localparam logic [30:0] GEN2_START = 31'd123456789;
  localparam logic [30:0] SEED_MAX = 31'd2147483562;

  // Run shaping. The hold-off outlasts a reseeded draw, so results back up.
  localparam int PHASE_DRAWS = 110;
  localparam int RESEED_PCT = 6;
  localparam int HOLD_CYCLES = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [30:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;     // [0] reseed, [7:1] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;     // [30:0] value, [31] zero

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  // Tracks the generator pair, the shuffle table and the values still owed.
  class lcg_draw_board;
    logic [30:0] seed_reg;
    logic [30:0] gen1;
    logic [30:0] gen2;
    logic [30:0] prev_value;
    logic [30:0] shuffle_slots [SLOTS];
    logic [30:0] expected_draws [$];
    int          errors;

    function new();
      seed_reg = 31'd1;
      gen1 = 31'd1;
      gen2 = GEN2_START;
      prev_value = 31'd0;
      foreach (shuffle_slots[i]) shuffle_slots[i] = 31'd0;
      errors = 0;
    endfunction

    // One multiplicative step by Schrage's decomposition.
    function logic [30:0] schrage(logic [30:0] x, longint mul, longint quo,
                                  longint rem, longint modulus);
      longint v;
      longint k;
      longint r;
      v = longint'(x);
      k = v / quo;
      r = mul * (v - k * quo) - k * rem;
      if (r < 0) r += modulus;
      return r[30:0];
    endfunction

    function void set_seed(logic [30:0] value);
      seed_reg = value;
    endfunction

    // Works out the value that one accepted request must produce.
    function void note_draw(logic reseed);
      logic [30:0] start;
      int          slot;
      longint      diff;
      if (reseed) begin
        start = (seed_reg == 31'd0) ? 31'd1 : seed_reg;
        gen1 = start;
        gen2 = start;
        for (int j = WARMUP - 1; j >= 0; j--) begin
          gen1 = schrage(gen1, MULT_1, QUOT_1, REMD_1, MODULUS_1);
          if (j < SLOTS) shuffle_slots[j] = gen1;
        end
        prev_value = shuffle_slots[0];
      end
      gen1 = schrage(gen1, MULT_1, QUOT_1, REMD_1, MODULUS_1);
      gen2 = schrage(gen2, MULT_2, QUOT_2, REMD_2, MODULUS_2);
      slot = int'(longint'(prev_value) / SLOT_WIDTH);
      if (slot >= SLOTS) slot = SLOTS - 1;
      diff = longint'(shuffle_slots[slot]) - longint'(gen2);
      shuffle_slots[slot] = gen1;
      if (diff < 1) diff += RANGE_TOP;
      prev_value = diff[30:0];
      expected_draws.push_back(prev_value);
    endfunction

    function void check_draw(logic [30:0] actual);
      logic [30:0] want;
      if (expected_draws.size() == 0) begin
        $error("value: unexpected result %0d with nothing expected", actual);
        errors++;
      end else begin
        want = expected_draws.pop_front();
        if (actual !== want) begin
          $error("value: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction
  endclass

  lcg_draw_board board;

  combined_lcg_shuffle_rng dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record every accepted request beat and check every accepted result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_draw(s_tdata[0]);
      if (m_tvalid && m_tready) board.check_draw(m_tdata[30:0]);
    end
  end

  // Stop the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Present one request beat after random idle cycles and wait for acceptance.
  task automatic send_beat(input logic reseed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, reseed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed value has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Seed writes happen only while the block is idle.
  task automatic write_seed(input logic [30:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_seed(value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall, input bit hold);
    logic [30:0] phase_seed;
    phase_seed = 31'($urandom_range(0, 2147483562));
    write_seed(phase_seed);
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    // A long receiver hold-off while requests keep coming fills the block.
    if (hold) hold_request = 1'b1;
    send_beat(1'b1);
    for (int n = 1; n < PHASE_DRAWS; n++) begin
      if (n == PHASE_DRAWS / 2) drain();
      send_beat($urandom_range(99) < RESEED_PCT);
    end
    drain();
  endtask

  initial begin
    board = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 31'd0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight from reset: all-zero table and previous output zero, so slot 0.
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b0);
    // Reseed from the seed register's reset value.
    send_beat(1'b1);
    send_beat(1'b0);
    drain();

    // A zero seed behaves as one.
    write_seed(31'd0);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();

    // Largest seed, which is above the second modulus.
    write_seed(SEED_MAX);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    drain();

    // A seed equal to the second modulus pins that generator at zero.
    write_seed(MODULUS_2[30:0]);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();

    // Alternating bit patterns in the seed.
    write_seed(31'h2AAAAAAA);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();
    write_seed(31'h55555555);
    send_beat(1'b1);
    send_beat(1'b0);
    drain();

    // Random phases under different flow control.
    run_phase(0, 0, 1'b1);
    run_phase(86, 0, 1'b0);
    run_phase(0, 86, 1'b0);
    run_phase(18, 18, 1'b0);

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $error("value: %0d expected results never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
